@@ design/assert_macros.svh @@
// Assertion macros for the checker file.
// Depends on nothing; included by the checker module only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising edge, quiet while reset is asserted.
`define SEM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked at every rising edge, quiet while reset is asserted.
`define SEM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ design/sem_pkg.sv @@
// Package for the Sobel edge magnitude block: constants, types and the RGB to luma function.
// Depends on nothing.
`default_nettype none
package sem_pkg;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_IS_RGB = 2'd2;
	localparam int CFG_DATA_W = 13;

	localparam logic [11:0] WIDTH_RESET  = 12'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;

	localparam logic [15:0] COEF_R = 16'd14516;
	localparam logic [15:0] COEF_G = 16'd46885;
	localparam logic [15:0] COEF_B = 16'd4725;
	localparam logic [7:0]  PIX_MAX = 8'd255;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] luma;
	} pixel_t;

	typedef struct packed {
		logic [7:0]  edge_value;
		logic [11:0] out_row;
		logic [10:0] out_col;
		logic        frame_end;
	} result_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;     // capture pixel and start line store read
		logic compute;  // read data valid: form window and gradient
		logic finish;   // square root step done, register the result
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic emit;     // current pixel produces a result
		logic root_busy;
	} dp_sts_t;

	function automatic logic [7:0] rgb_to_luma(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		logic [25:0] s;
		begin
			s = (26'(r) * 26'(COEF_R)) + (26'(g) * 26'(COEF_G)) + (26'(b) * 26'(COEF_B));
			rgb_to_luma = (s[25:16] > 10'd255) ? PIX_MAX : s[23:16];
		end
	endfunction
endpackage
`default_nettype wire

@@ design/sem_if.sv @@
// Valid/ready stream interface carrying a generic payload.
// Depends on nothing; used with payload types from sem_pkg.
`default_nettype none
interface sem_stream_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/sem_ram.sv @@
// Generic single port RAM with registered read.
// Depends on nothing.
`default_nettype none
module sem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[addr];
		end
		if (we) begin
			mem_q[addr] <= wdata;
		end
	end
endmodule
`default_nettype wire

@@ design/sem_ctrl.sv @@
// Controller state machine of the Sobel block: handshakes and sequencing of the datapath.
// Depends on sem_pkg.
`default_nettype none
module sem_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire sem_pkg::dp_sts_t sts,
	output sem_pkg::dp_cmd_t      cmd
);
	import sem_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_ROOT = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.compute = 1'b1;
				state_d     = sts.emit ? ST_ROOT : ST_IDLE;
			end
			ST_ROOT: begin
				if (!sts.root_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_OUT;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

@@ design/sem_datapath.sv @@
// Datapath of the Sobel block: luma, line stores, window, gradient and iterative square root.
// Depends on sem_pkg and sem_ram.
`default_nettype none
module sem_datapath #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sem_pkg::pixel_t  pix,
	input  wire logic [11:0]      frame_width,
	input  wire logic [12:0]      frame_height,
	input  wire logic             input_is_rgb,
	input  wire sem_pkg::dp_cmd_t cmd,
	output sem_pkg::dp_sts_t      sts,
	output sem_pkg::result_t      result
);
	import sem_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = AW + 1;                 // column counter, holds MAX_WIDTH
	localparam int RW = $clog2(MAX_HEIGHT) + 1;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [7:0]    y_q;
	logic [7:0]    top_rd, mid_rd;
	logic [7:0]    win_q [6];
	logic [CW-1:0] w_eff;
	logic [RW-1:0] h_eff;
	logic          emit_c;
	logic          fend_q;
	logic [11:0]   orow_q;
	logic [10:0]   ocol_q;

	// Effective frame size saturated to the supported range.
	always_comb begin
		if (frame_width < 12'd3) begin
			w_eff = CW'(3);
		end else if (32'(frame_width) > MAX_WIDTH) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(frame_width);
		end
		if (frame_height < 13'd3) begin
			h_eff = RW'(3);
		end else if (32'(frame_height) > MAX_HEIGHT) begin
			h_eff = RW'(MAX_HEIGHT);
		end else begin
			h_eff = RW'(frame_height);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			y_q <= input_is_rgb ? rgb_to_luma(pix.red, pix.green, pix.blue) : pix.luma;
		end
	end

	sem_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
		.clk(clk), .we(cmd.compute), .re(cmd.load), .addr(col_q[AW-1:0]),
		.wdata(mid_rd), .rdata(top_rd));
	sem_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_middle (
		.clk(clk), .we(cmd.compute), .re(cmd.load), .addr(col_q[AW-1:0]),
		.wdata(y_q), .rdata(mid_rd));

	assign emit_c = (row_q >= RW'(2)) && (col_q >= CW'(2)) && (row_q < h_eff) && (col_q < w_eff);

	// Gradient of the current window.
	logic signed [11:0] gx, gy;
	logic        [10:0] ax, ay;
	logic        [21:0] n_c;
	always_comb begin
		gx = (12'(top_rd) + {3'b0, mid_rd, 1'b0} + 12'(y_q))
		   - (12'(win_q[0]) + {3'b0, win_q[1], 1'b0} + 12'(win_q[2]));
		gy = (12'(win_q[2]) + {3'b0, win_q[5], 1'b0} + 12'(y_q))
		   - (12'(win_q[0]) + {3'b0, win_q[3], 1'b0} + 12'(top_rd));
		ax = gx[11] ? 11'(-gx) : 11'(gx);
		ay = gy[11] ? 11'(-gy) : 11'(gy);
		n_c = (22'(ax) * 22'(ax)) + (22'(ay) * 22'(ay));
	end

	// Control counters and window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.compute) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_rd;
			win_q[4] <= mid_rd;
			win_q[5] <= y_q;
			if (col_q + CW'(1) >= w_eff) begin
				col_q <= '0;
				row_q <= (row_q + RW'(1) >= h_eff) ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.compute) begin
			orow_q <= 12'(row_q - RW'(1));
			ocol_q <= 11'(col_q - CW'(1));
			fend_q <= (row_q == h_eff - RW'(1)) && (col_q == w_eff - CW'(1));
		end
	end

	// Bit-serial square root, one result bit per cycle.
	logic [21:0] n_q;
	logic [7:0]  res_q;
	logic [7:0]  bit_q;
	logic        sat_q;
	logic [7:0]  trial;
	logic [15:0] sq;
	assign trial = res_q | bit_q;
	assign sq    = trial * trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (cmd.compute && emit_c) begin
			bit_q <= 8'h80;
		end else if (bit_q != 8'd0) begin
			bit_q <= bit_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.compute && emit_c) begin
			n_q   <= n_c;
			sat_q <= n_c >= 22'd65536;
			res_q <= '0;
		end else if (bit_q != 8'd0) begin
			if (22'(sq) <= n_q) begin
				res_q <= trial;
			end
		end
		if (cmd.finish) begin
			result.edge_value <= sat_q ? PIX_MAX : res_q;
			result.out_row    <= orow_q;
			result.out_col    <= ocol_q;
			result.frame_end  <= fend_q;
		end
	end

	assign sts.emit      = emit_c;
	assign sts.root_busy = bit_q != 8'd0;
endmodule
`default_nettype wire

@@ design/sobel_edge_magnitude_top.sv @@
// Top level of the Sobel edge magnitude block: configuration registers, controller, datapath.
// Depends on sem_pkg, sem_stream_if, sem_ctrl and sem_datapath.
`default_nettype none
// The block takes pixels in raster order and returns, for every interior pixel, the clamped
// Sobel gradient magnitude with the centre pixel's row and column; border pixels give no
// transaction. A new pixel is accepted only once the previous one is finished: after the
// registered line store read for a pixel that gives no result, and also after the
// bit-serial square root, which resolves one bit per cycle, and the result handshake for
// one that does. Configuration writes are accepted at any time, but are meant for idle.
module sobel_edge_magnitude_top #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	sem_stream_if.sink                       pix_in,
	sem_stream_if.source                     res_out,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sem_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sem_pkg::*;

	logic [11:0] frame_width_q;
	logic [12:0] frame_height_q;
	logic        input_is_rgb_q;
	dp_cmd_t     cmd;
	dp_sts_t     sts;
	result_t     result;

	// Configuration writes are always accepted.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
			input_is_rgb_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[11:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				REG_INPUT_IS_RGB: input_is_rgb_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	sem_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(pix_in.valid), .in_ready(pix_in.ready),
		.out_valid(res_out.valid), .out_ready(res_out.ready),
		.sts(sts), .cmd(cmd));

	// The datapath captures the pixel only on the load command, so the payload is sampled
	// at the accepting edge.
	sem_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
		.clk(clk), .arst_n(arst_n), .pix(pix_in.data),
		.frame_width(frame_width_q), .frame_height(frame_height_q),
		.input_is_rgb(input_is_rgb_q), .cmd(cmd), .sts(sts), .result(result));

	assign res_out.data = result;
endmodule
`default_nettype wire

@@ design/sem_checker.sv @@
// Port-level checker for the Sobel block, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sem_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [11:0] out_row,
	input wire logic [10:0] out_col
);
	// A result and a new pixel are never offered together.
	`SEM_ASSERT_IMPL(a_excl, clk, arst_n, out_valid, !in_ready)
	// After a pixel is accepted the input is closed in the next cycle.
	`SEM_ASSERT_NEXT(a_gap, clk, arst_n, in_valid && in_ready, !in_ready)
	// Reported coordinates are interior, never row or column zero.
	`SEM_ASSERT_IMPL(a_interior, clk, arst_n, out_valid, out_row != 12'd0 && out_col != 11'd0)
	// A stalled result stays offered.
	`SEM_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule
bind sobel_edge_magnitude_top sem_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(pix_in.valid), .in_ready(pix_in.ready),
	.out_valid(res_out.valid), .out_ready(res_out.ready),
	.out_row(res_out.data.out_row), .out_col(res_out.data.out_col));
`default_nettype wire

@@ test/sobel_edge_magnitude_top_test.sv @@
// Self-checking testbench for sobel_edge_magnitude_top: raster frames in, edge results checked.
// Depends on sem_pkg, sem_stream_if and the block itself; needs no other file.
`timescale 1ns / 1ps
module sobel_edge_magnitude_top_test;
	import sem_pkg::*;

	localparam int LINE_DEPTH = 2048;
	localparam int ROW_LIMIT  = 4096;
	localparam int CYCLE_CAP  = 3000000;
	// Longest quiet stretch of the block after its last result, with margin.
	localparam int SETTLE_CYCLES = 24;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sem_stream_if #(.T(pixel_t))  pix_if (clk);
	sem_stream_if #(.T(result_t)) res_if (clk);

	sobel_edge_magnitude_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_if.sink),
		.res_out   (res_if.source),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Pixels waiting for the driver, and edge results the block still owes us.
	pixel_t  pixel_q[$];
	result_t edge_q[$];

	// Our own copy of the block's registers and streaming state.
	logic [11:0] width_reg;
	logic [12:0] height_reg;
	logic        rgb_reg;
	logic [7:0]  upper_line [LINE_DEPTH];
	logic [7:0]  middle_line [LINE_DEPTH];
	logic [7:0]  window [6];
	int          row_pos;
	int          col_pos;

	int send_idle_pct;
	int recv_idle_pct;
	int errors;
	int pixels_sent;
	int results_seen;
	int frames_sent;
	int cycle_count;

	// Clock: 8 ns period.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Luma as the block derives it: Q0.16 weights, then clamped to one byte.
	function automatic int pixel_luma(pixel_t p, logic rgb);
		int s;
		if (!rgb)
			return p.luma;
		s = (14516 * p.red + 46885 * p.green + 4725 * p.blue) >> 16;
		return (s > 255) ? 255 : s;
	endfunction

	// Integer square root, one bit at a time, saturating at a full byte.
	function automatic int edge_root(int n);
		int res;
		int t;
		res = 0;
		if (n >= 65536)
			return 255;
		for (int b = 128; b != 0; b >>= 1) begin
			t = res | b;
			if (t * t <= n)
				res = t;
		end
		return res;
	endfunction

	// Advances the predicted pipeline by one accepted pixel and queues any edge result.
	task automatic advance_edge_state(pixel_t p);
		int w;
		int h;
		int y;
		int ci;
		int top;
		int mid;
		int gx;
		int gy;
		result_t e;
		w = (width_reg < 3) ? 3 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg);
		h = (height_reg < 3) ? 3 : ((height_reg > ROW_LIMIT) ? ROW_LIMIT : height_reg);
		y = pixel_luma(p, rgb_reg);
		ci = col_pos % LINE_DEPTH;
		top = upper_line[ci];
		mid = middle_line[ci];
		upper_line[ci] = mid[7:0];
		middle_line[ci] = y[7:0];
		if (row_pos >= 2 && col_pos >= 2 && row_pos < h && col_pos < w) begin
			// Window columns: left (c-2) in slots 0..2, centre (c-1) in 3..5.
			gx = (top + 2 * mid + y) - (window[0] + 2 * window[1] + window[2]);
			gy = (window[2] + 2 * window[5] + y) - (window[0] + 2 * window[3] + top);
			e.edge_value = 8'(edge_root(gx * gx + gy * gy));
			e.out_row = 12'(row_pos - 1);
			e.out_col = 11'(col_pos - 1);
			e.frame_end = (row_pos == h - 1 && col_pos == w - 1);
			edge_q.push_back(e);
		end
		window[0] = window[3];
		window[1] = window[4];
		window[2] = window[5];
		window[3] = top[7:0];
		window[4] = mid[7:0];
		window[5] = y[7:0];
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h)
				row_pos = 0;
		end
		col_pos &= 'h7FF;
		row_pos &= 'hFFF;
	endtask

	// Pixel driver: holds a transaction until it is taken, then maybe pauses.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_if.valid <= 1'b0;
			pix_if.data <= '0;
		end else if (!pix_if.valid || pix_if.ready) begin
			if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				pix_if.valid <= 1'b1;
				pix_if.data <= pixel_q.pop_front();
			end else begin
				pix_if.valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: predicts on every accepted pixel and checks every accepted result.
	always @(posedge clk) begin
		if (arst_n && pix_if.valid && pix_if.ready) begin
			advance_edge_state(pix_if.data);
			pixels_sent++;
		end
		if (arst_n && res_if.valid && res_if.ready) begin
			results_seen++;
			if (edge_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: row %0d col %0d value %0d",
					$time, res_if.data.out_row, res_if.data.out_col,
					res_if.data.edge_value);
			end else begin
				result_t e;
				e = edge_q.pop_front();
				if (res_if.data.edge_value !== e.edge_value) begin
					errors++;
					$display("%0t: edge_value expected %0d actual %0d", $time,
						e.edge_value, res_if.data.edge_value);
				end
				if (res_if.data.out_row !== e.out_row) begin
					errors++;
					$display("%0t: out_row expected %0d actual %0d", $time,
						e.out_row, res_if.data.out_row);
				end
				if (res_if.data.out_col !== e.out_col) begin
					errors++;
					$display("%0t: out_col expected %0d actual %0d", $time,
						e.out_col, res_if.data.out_col);
				end
				if (res_if.data.frame_end !== e.frame_end) begin
					errors++;
					$display("%0t: frame_end expected %0d actual %0d", $time,
						e.frame_end, res_if.data.frame_end);
				end
			end
		end
	end

	// Watchdog. The cap is far above the slowest correct run of this stimulus.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_CAP) begin
			$display("%0t: timeout with %0d results outstanding", $time, edge_q.size());
			$display("FAIL sobel_edge_magnitude_top");
			$finish;
		end
	end

	// Waits until every pixel is taken and every result has come back, then lets the
	// block drain any pixel that produces nothing before we touch its registers.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pixel_q.size() != 0 || pix_if.valid || edge_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One configuration transaction; our copy of the register follows at acceptance.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH:  width_reg = value[11:0];
			REG_FRAME_HEIGHT: height_reg = value[12:0];
			REG_INPUT_IS_RGB: rgb_reg = value[0];
			default: ;
		endcase
	endtask

	// Pixel content styles: fully random, rail-to-rail fields, a noisy ramp that keeps
	// gradients in the middle of the range, or a checkerboard.
	typedef enum int {FILL_RANDOM, FILL_RAILS, FILL_RAMP, FILL_CHECKER} fill_e;

	function automatic pixel_t make_pixel(fill_e fill, int r, int c);
		pixel_t p;
		int base;
		p = pixel_t'($urandom);
		case (fill)
			FILL_RAILS: begin
				p.red = $urandom_range(1) ? 8'hFF : 8'h00;
				p.green = $urandom_range(1) ? 8'hFF : 8'h00;
				p.blue = $urandom_range(1) ? 8'hFF : 8'h00;
				p.luma = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			FILL_RAMP: begin
				base = (r * 23 + c * 11) & 'hFF;
				p.luma = 8'(base ^ $urandom_range(7));
				p.green = 8'(base ^ $urandom_range(7));
			end
			FILL_CHECKER: begin
				p.luma = ((r + c) & 1) ? 8'hFF : 8'h00;
				p.red = p.luma;
				p.green = p.luma;
				p.blue = p.luma;
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic queue_rows(int w, int first_row, int rows, fill_e fill);
		for (int r = first_row; r < first_row + rows; r++)
			for (int c = 0; c < w; c++)
				pixel_q.push_back(make_pixel(fill, r, c));
	endtask

	// Sets size and luma source, queues a frame; the block saturates out-of-range sizes.
	task automatic queue_frame(int w_reg, int h_reg, int rgb, fill_e fill);
		int w;
		int h;
		wait_drained();
		write_reg(REG_FRAME_WIDTH, w_reg);
		write_reg(REG_FRAME_HEIGHT, h_reg);
		write_reg(REG_INPUT_IS_RGB, rgb);
		w = (w_reg < 3) ? 3 : ((w_reg > LINE_DEPTH) ? LINE_DEPTH : w_reg);
		h = (h_reg < 3) ? 3 : ((h_reg > ROW_LIMIT) ? ROW_LIMIT : h_reg);
		queue_rows(w, 0, h, fill);
		frames_sent++;
	endtask

	initial begin
		int target;
		int w;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		pixels_sent = 0;
		results_seen = 0;
		frames_sent = 0;
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		rgb_reg = 1'b0;
		row_pos = 0;
		col_pos = 0;
		for (int i = 0; i < 6; i++)
			window[i] = '0;
		for (int i = 0; i < LINE_DEPTH; i++) begin
			upper_line[i] = '0;
			middle_line[i] = '0;
		end
		send_idle_pct = 18;
		recv_idle_pct = 84;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed frames, all the smallest size. A checkerboard gives zero magnitude, as its
		// Sobel sums cancel; rail-to-rail fields give random extreme gradients. In RGB mode the
		// all-white triple sums past 255 and exercises the luma clamp, while in the rail frame the
		// luma byte carries random values that must be ignored.
		queue_frame(3, 3, 0, FILL_CHECKER);
		queue_frame(3, 3, 0, FILL_RAILS);
		queue_frame(3, 3, 1, FILL_CHECKER);
		queue_frame(0, 0, 1, FILL_RAILS);

		// Random frames under three idling patterns.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 18 : ((ph == 1) ? 84 : 0);
			recv_idle_pct = (ph == 0) ? 84 : ((ph == 1) ? 18 : 0);
			target = pixels_sent + 190;
			while (pixels_sent + pixel_q.size() < target) begin
				if ($urandom_range(7) == 0) begin
					// Height rewritten mid-frame: either still ahead of the current
					// row, or already passed so that the row counter overruns it.
					w = $urandom_range(12, 3);
					queue_frame(w, 8, $urandom_range(1), FILL_RAMP);
					pixel_q = pixel_q[0:(4 * w) - 1];
					wait_drained();
					write_reg(REG_FRAME_HEIGHT, $urandom_range(1) ? 5 : 3);
					queue_rows(w, 4, 1, FILL_RANDOM);
				end else begin
					queue_frame($urandom_range(12, 3), $urandom_range(8, 3),
						$urandom_range(1), fill_e'($urandom_range(3)));
				end
			end
		end

		wait_drained();
		$display("Covered %0d frames, %0d pixels and %0d edge results", frames_sent,
			pixels_sent, results_seen);
		$display("across three handshake pressure patterns and both luma sources.");
		if (errors == 0) begin
			$display("PASS sobel_edge_magnitude_top");
		end else begin
			$display("%0d mismatches", errors);
			$display("FAIL sobel_edge_magnitude_top");
		end
		$finish;
	end
endmodule

@@ sobel_edge_magnitude_top.f @@
+incdir+design
design/sem_pkg.sv
design/sem_if.sv
design/sem_ram.sv
design/sem_ctrl.sv
design/sem_datapath.sv
design/sobel_edge_magnitude_top.sv
design/sem_checker.sv
test/sobel_edge_magnitude_top_test.sv
